// ===== src/packet_release_pacer_defines.svh =====
// assertion macros for the packet release pacer
// used by prp_div and packet_release_pacer; no other dependencies
`ifndef PACKET_RELEASE_PACER_DEFINES_SVH
`define PACKET_RELEASE_PACER_DEFINES_SVH
`ifndef ASSERT_OFF
`define PRP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PRP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PRP_ASSERT(lbl, prop, msg)
`define PRP_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ===== src/prp_pkg.sv =====
// shared widths, codes and constants for the packet release pacer
// no dependencies
package prp_pkg;

  localparam int TIME_W     = 64;
  localparam int RATE_W     = 37;
  localparam int INTERVAL_W = 32;
  localparam int SEC_W      = 32;
  localparam int NSEC_W     = 30;
  localparam int MODE_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int INDEX_W    = 2;
  localparam int LEN_WIDTH_DEF = 16;
  localparam int BYTE_SHIFT = 3;

  localparam logic [NSEC_W-1:0] NS_PER_SEC = 30'd1000000000;
  localparam logic [RATE_W-1:0] RATE_MIN   = 37'd2;
  localparam logic [RATE_W-1:0] RATE_RESET = 37'd1000000;

  localparam logic [MODE_W-1:0] MODE_INTERVAL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RATE     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REPLAY   = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_PACED   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_UNPACED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd2;

  localparam logic [INDEX_W-1:0] REG_MODE     = 2'd0;
  localparam logic [INDEX_W-1:0] REG_INTERVAL = 2'd1;
  localparam logic [INDEX_W-1:0] REG_RATE     = 2'd2;
  localparam logic [INDEX_W-1:0] REG_START    = 2'd3;

endpackage

// ===== src/prp_div.sv =====
// radix-2 restoring divider, one quotient bit per cycle, saturating quotient
// depends on prp_pkg and packet_release_pacer_defines.svh
`include "packet_release_pacer_defines.svh"
module prp_div #(
  parameter int NUM_W = prp_pkg::TIME_W + 1,
  parameter int DEN_W = prp_pkg::RATE_W,
  parameter int Q_W   = prp_pkg::TIME_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [Q_W-1:0]   quot
);

  localparam int HI_W  = NUM_W - Q_W;
  localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;
  localparam int CNT_W = $clog2(Q_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_q;
  logic [Q_W-1:0]   lo;
  logic [DEN_W:0]   shifted;
  logic             fits;
  logic             sat;

  assign sat     = CMP_W'(num[NUM_W-1:Q_W]) >= CMP_W'(den);
  assign shifted = {rem, lo[Q_W-1]};
  assign fits    = shifted >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (sat) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_q <= den;
      cnt   <= CNT_W'(Q_W - 1);
      lo    <= num[Q_W-1:0];
      rem   <= DEN_W'(num[NUM_W-1:Q_W]);
      quot  <= sat ? '1 : '0;
    end else if (busy) begin
      cnt  <= cnt - 1'b1;
      lo   <= {lo[Q_W-2:0], 1'b0};
      rem  <= fits ? DEN_W'(shifted - {1'b0, den_q}) : shifted[DEN_W-1:0];
      quot <= {quot[Q_W-2:0], fits};
    end
  end

  `PRP_ASSERT(a_start_idle, start |-> !busy, "divider started while busy")
  `PRP_ASSERT(a_last_done, busy && cnt == '0 && !start |=> done, "divider missed done")
  `PRP_ASSERT_RST(a_reset_clear, rst |=> !busy && !done, "divider not cleared by reset")

endmodule

// ===== src/packet_release_pacer.sv =====
// path from the input accept to out_valid: interval mode, no timestamp or drop go to the final state
// and the output register; timestamp replay runs multiply, stamp, offset, schedule, output;
// bit-rate mode runs multiply, divider start and the bit-serial divider, then output.
// one packet at a time: a new packet is accepted only once the last has left the final state.
// synchronous reset clears control, schedule state and configuration to their reset values.
`include "packet_release_pacer_defines.svh"
module packet_release_pacer #(
  parameter int LEN_WIDTH = prp_pkg::LEN_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [LEN_WIDTH-1:0]          pkt_len_bytes,
  input  logic                          has_timestamp,
  input  logic signed [prp_pkg::SEC_W-1:0] stamp_sec,
  input  logic [prp_pkg::NSEC_W-1:0]    stamp_nsec,
  input  logic [prp_pkg::TIME_W-1:0]    arrival_ns,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [prp_pkg::TIME_W-1:0]    release_ns,
  output logic [prp_pkg::STATUS_W-1:0]  status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [prp_pkg::INDEX_W-1:0]   cfg_index,
  input  logic [prp_pkg::TIME_W-1:0]    cfg_data
);

  import prp_pkg::*;

  localparam int MW    = (LEN_WIDTH > SEC_W - 1) ? LEN_WIDTH : SEC_W - 1;
  localparam int PW    = MW + NSEC_W;
  localparam int NUM_W = (LEN_WIDTH + NSEC_W + BYTE_SHIFT > TIME_W + 1) ?
                         LEN_WIDTH + NSEC_W + BYTE_SHIFT : TIME_W + 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MUL    = 3'd1;
  localparam logic [2:0] S_DSTART = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_PTS    = 3'd4;
  localparam logic [2:0] S_OFS    = 3'd5;
  localparam logic [2:0] S_SCH    = 3'd6;
  localparam logic [2:0] S_FIN    = 3'd7;

  localparam logic [2:0] K_INTERVAL = 3'd0;
  localparam logic [2:0] K_RATE     = 3'd1;
  localparam logic [2:0] K_STAMP    = 3'd2;
  localparam logic [2:0] K_NOTS     = 3'd3;
  localparam logic [2:0] K_DROP     = 3'd4;

  logic [2:0]            state;
  logic [2:0]            state_next;
  logic [2:0]            kind;
  logic [2:0]            kind_next;

  logic [MODE_W-1:0]     pacing_mode;
  logic [INTERVAL_W-1:0] interval_ns;
  logic [RATE_W-1:0]     rate_bps;
  logic [TIME_W-1:0]     start_time_ns;
  logic [TIME_W-1:0]     next_due;
  logic [TIME_W-1:0]     first_stamp;
  logic                  first_seen;

  logic [LEN_WIDTH-1:0]  len_q;
  logic [SEC_W-2:0]      sec_low;
  logic [NSEC_W-1:0]     nsec_q;
  logic [TIME_W-1:0]     arr_q;

  logic [MW-1:0]         mul_op;
  logic [PW-1:0]         mul_q;
  logic [TIME_W-1:0]     pts;
  logic [TIME_W-1:0]     first_eff;
  logic                  stamp_ge;
  logic [TIME_W-1:0]     mag;
  logic [TIME_W:0]       sch_sum;
  logic [TIME_W:0]       sch_dif;
  logic [TIME_W-1:0]     sched;
  logic [TIME_W-1:0]     sched_q;

  logic                  in_fire;
  logic                  cfg_fire;
  logic                  fin_fire;
  logic                  out_free;
  logic                  div_start;
  logic                  div_done;
  logic [NUM_W-1:0]      div_num;
  logic [TIME_W-1:0]     div_quot;

  logic [TIME_W-1:0]     step;
  logic [TIME_W:0]       due_sum;
  logic [TIME_W-1:0]     base;
  logic [TIME_W-1:0]     later_time;
  logic [TIME_W-1:0]     rel_time;
  logic [STATUS_W-1:0]   rel_status;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign out_free  = !out_valid || out_ready;
  assign fin_fire  = (state == S_FIN) && out_free;
  assign div_start = (state == S_DSTART);
  assign div_num   = NUM_W'({mul_q[LEN_WIDTH+NSEC_W-1:0], {BYTE_SHIFT{1'b0}}});
  assign mul_op    = (kind == K_RATE) ? MW'(len_q) : MW'(sec_low);

  // packet class at accept
  always_comb begin
    if (pacing_mode == MODE_INTERVAL) begin
      kind_next = K_INTERVAL;
    end else if (pacing_mode == MODE_RATE && rate_bps >= RATE_MIN) begin
      kind_next = K_RATE;
    end else if (!has_timestamp) begin
      kind_next = K_NOTS;
    end else if (stamp_sec[SEC_W-1]) begin
      kind_next = K_DROP;
    end else begin
      kind_next = K_STAMP;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (kind_next == K_RATE || kind_next == K_STAMP) begin
            state_next = S_MUL;
          end else begin
            state_next = S_FIN;
          end
        end
      end
      S_MUL:    state_next = (kind == K_RATE) ? S_DSTART : S_PTS;
      S_DSTART: state_next = S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_next = S_FIN;
        end
      end
      S_PTS:    state_next = S_OFS;
      S_OFS:    state_next = S_SCH;
      S_SCH:    state_next = S_FIN;
      S_FIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // replay offset
  assign first_eff = first_seen ? first_stamp : pts;
  assign sch_sum   = {1'b0, start_time_ns} + {1'b0, mag};
  assign sch_dif   = {1'b0, start_time_ns} - {1'b0, mag};

  always_comb begin
    if (stamp_ge) begin
      sched = sch_sum[TIME_W] ? '1 : sch_sum[TIME_W-1:0];
    end else begin
      sched = sch_dif[TIME_W] ? '0 : sch_dif[TIME_W-1:0];
    end
  end

  // release and schedule update
  assign step       = (kind == K_RATE) ? div_quot : TIME_W'(interval_ns);
  assign due_sum    = {1'b0, next_due} + {1'b0, step};
  assign base       = (kind == K_STAMP) ? sched_q : next_due;
  assign later_time = (base > arr_q) ? base : arr_q;

  always_comb begin
    case (kind)
      K_NOTS: begin
        rel_time   = arr_q;
        rel_status = STATUS_UNPACED;
      end
      K_DROP: begin
        rel_time   = '0;
        rel_status = STATUS_DROPPED;
      end
      default: begin
        rel_time   = later_time;
        rel_status = STATUS_PACED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      kind  <= K_INTERVAL;
    end else begin
      state <= state_next;
      if (in_fire) begin
        kind <= kind_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      len_q   <= pkt_len_bytes;
      sec_low <= stamp_sec[SEC_W-2:0];
      nsec_q  <= stamp_nsec;
      arr_q   <= arrival_ns;
    end
    if (state == S_MUL) begin
      mul_q <= PW'(mul_op) * PW'(NS_PER_SEC);
    end
    if (state == S_PTS) begin
      pts <= TIME_W'(mul_q) + TIME_W'(nsec_q);
    end
    if (state == S_OFS) begin
      stamp_ge <= pts >= first_eff;
      mag      <= (pts >= first_eff) ? pts - first_eff : first_eff - pts;
    end
    if (state == S_SCH) begin
      sched_q <= sched;
    end
  end

  // configuration and schedule state
  always_ff @(posedge clk) begin
    if (rst) begin
      pacing_mode   <= MODE_REPLAY;
      interval_ns   <= '0;
      rate_bps      <= RATE_RESET;
      start_time_ns <= '0;
      next_due      <= '0;
      first_stamp   <= '0;
      first_seen    <= 1'b0;
    end else begin
      if (state == S_OFS) begin
        first_seen  <= 1'b1;
        first_stamp <= first_eff;
      end
      if (state == S_SCH) begin
        next_due <= sched;
      end
      if (fin_fire && (kind == K_RATE || kind == K_INTERVAL)) begin
        next_due <= due_sum[TIME_W] ? '1 : due_sum[TIME_W-1:0];
      end
      if (cfg_fire) begin
        case (cfg_index)
          REG_MODE:     pacing_mode <= cfg_data[MODE_W-1:0];
          REG_INTERVAL: interval_ns <= cfg_data[INTERVAL_W-1:0];
          REG_RATE:     rate_bps    <= cfg_data[RATE_W-1:0];
          REG_START: begin
            start_time_ns <= cfg_data;
            next_due      <= cfg_data;
          end
          default: ;
        endcase
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_fire) begin
      release_ns <= rel_time;
      status     <= rel_status;
    end
  end

  prp_div #(
    .NUM_W (NUM_W),
    .DEN_W (RATE_W),
    .Q_W   (TIME_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (rate_bps),
    .done  (div_done),
    .quot  (div_quot)
  );

  `PRP_ASSERT(a_done_in_div, div_done |-> state == S_DIV, "divider done outside wait state")
  `PRP_ASSERT(a_drop_zero, out_valid && status == STATUS_DROPPED |-> release_ns == '0, "drop with nonzero time")
  `PRP_ASSERT(a_status_code, out_valid |-> status <= STATUS_DROPPED, "bad status")
  `PRP_ASSERT(a_due_mono, fin_fire && (kind == K_RATE || kind == K_INTERVAL) && !(cfg_valid && cfg_index == REG_START) |=> next_due >= $past(next_due), "schedule went backward")

endmodule
